/* hdl/tsgt_pkg.sv */
// Shared types, constants and helper functions for the touch stroke gesture tracker.
`timescale 1ns / 1ps

package tsgt_pkg;

   localparam int ZoneCount       = 3;
   localparam int CsrAddrWidth    = 5;
   localparam int CsrDataWidth    = 32;
   localparam int CfgWidth        = 16;
   localparam int TimeWidth       = 32;
   localparam int PosWidth        = 3;
   localparam int LevelWidth      = 2;

   localparam logic [PosWidth-1:0]   TravelHalfUnits = 3'd2;
   localparam logic [LevelWidth-1:0] LevelMax        = 2'd3;
   localparam logic [LevelWidth-1:0] LevelFirst      = 2'd1;

   localparam logic FuncTouch = 1'b0;
   localparam logic FuncTake  = 1'b1;

   typedef enum logic [2:0] {
      REG_ACTIVE_DURATION = 3'd0,
      REG_SPEECH_COOLDOWN = 3'd1,
      REG_TRAVEL_MIN      = 3'd2,
      REG_TRAVEL_MAX      = 3'd3,
      REG_STROKE_HOLDOFF  = 3'd4,
      REG_LEVEL_WINDOW    = 3'd5,
      REG_CLICK_QUIET     = 3'd6,
      REG_SPEECH_WINDOW   = 3'd7
   } reg_index_type;

   localparam logic [CfgWidth-1:0] ActiveDurationReset = 16'd4000;
   localparam logic [CfgWidth-1:0] SpeechCooldownReset = 16'd10000;
   localparam logic [CfgWidth-1:0] TravelMinReset      = 16'd60;
   localparam logic [CfgWidth-1:0] TravelMaxReset      = 16'd1400;
   localparam logic [CfgWidth-1:0] StrokeHoldoffReset  = 16'd300;
   localparam logic [CfgWidth-1:0] LevelWindowReset    = 16'd2500;
   localparam logic [CfgWidth-1:0] ClickQuietReset     = 16'd750;
   localparam logic [CfgWidth-1:0] SpeechWindowReset   = 16'd1800;

   typedef struct packed {
      logic [CfgWidth-1:0] active_duration_ms;
      logic [CfgWidth-1:0] speech_cooldown_ms;
      logic [CfgWidth-1:0] travel_min_ms;
      logic [CfgWidth-1:0] travel_max_ms;
      logic [CfgWidth-1:0] stroke_holdoff_ms;
      logic [CfgWidth-1:0] level_window_ms;
      logic [CfgWidth-1:0] click_quiet_ms;
      logic [CfgWidth-1:0] speech_window_ms;
   } cfg_type;

   typedef struct packed {
      logic                 func;
      logic [TimeWidth-1:0] now_ms;
      logic [ZoneCount-1:0] zone_mask;
      logic                 hw_swipe;
      logic                 enable;
   } item_type;

   typedef struct packed {
      logic                  stroke_event;
      logic                  speech_taken;
      logic                  is_active;
      logic [LevelWidth-1:0] intensity;
      logic                  suppress_clicks;
      logic                  speech_ready;
   } result_type;

   // centroid of the touched zones in half-zone units
   function automatic logic [PosWidth-1:0] pos_of_mask(input logic [ZoneCount-1:0] mask);
      logic [PosWidth-1:0] pos;
      case (mask)
         3'b001:  pos = 3'd0;
         3'b010:  pos = 3'd2;
         3'b011:  pos = 3'd1;
         3'b100:  pos = 3'd4;
         3'b101:  pos = 3'd2;
         3'b110:  pos = 3'd3;
         3'b111:  pos = 3'd2;
         default: pos = 3'd0;
      endcase
      return pos;
   endfunction

   function automatic logic [TimeWidth-1:0] widen(input logic [CfgWidth-1:0] value);
      return {{(TimeWidth-CfgWidth){1'b0}}, value};
   endfunction

endpackage

/* hdl/tsgt_req_if.sv */
// Request channel carrying touch samples and take-speech items.
`timescale 1ns / 1ps

interface tsgt_req_if;
   import tsgt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [TimeWidth-1:0] now_ms;
   logic [ZoneCount-1:0] zone_mask;
   logic                 hw_swipe;
   logic                 enable;

   modport source (output valid, func, now_ms, zone_mask, hw_swipe, enable, input ready);
   modport sink   (input valid, func, now_ms, zone_mask, hw_swipe, enable, output ready);
endinterface

/* hdl/tsgt_rsp_if.sv */
// Response channel carrying one result per request.
`timescale 1ns / 1ps

interface tsgt_rsp_if;
   import tsgt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  stroke_event;
   logic                  speech_taken;
   logic                  is_active;
   logic [LevelWidth-1:0] intensity;
   logic                  suppress_clicks;
   logic                  speech_ready;

   modport source (output valid, stroke_event, speech_taken, is_active, intensity,
                   suppress_clicks, speech_ready, input ready);
   modport sink   (input valid, stroke_event, speech_taken, is_active, intensity,
                   suppress_clicks, speech_ready, output ready);
endinterface

/* hdl/tsgt_csr.sv */
// APB configuration register file for the gesture tracker timing windows.
`timescale 1ns / 1ps

module tsgt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tsgt_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [tsgt_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [tsgt_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                csr_pready,
   output tsgt_pkg::cfg_type                   cfg
);
   import tsgt_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;
   logic [CfgWidth-1:0] rd_value;

   assign index      = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_ACTIVE_DURATION: cfg_in.active_duration_ms = csr_pwdata[CfgWidth-1:0];
            REG_SPEECH_COOLDOWN: cfg_in.speech_cooldown_ms = csr_pwdata[CfgWidth-1:0];
            REG_TRAVEL_MIN:      cfg_in.travel_min_ms      = csr_pwdata[CfgWidth-1:0];
            REG_TRAVEL_MAX:      cfg_in.travel_max_ms      = csr_pwdata[CfgWidth-1:0];
            REG_STROKE_HOLDOFF:  cfg_in.stroke_holdoff_ms  = csr_pwdata[CfgWidth-1:0];
            REG_LEVEL_WINDOW:    cfg_in.level_window_ms    = csr_pwdata[CfgWidth-1:0];
            REG_CLICK_QUIET:     cfg_in.click_quiet_ms     = csr_pwdata[CfgWidth-1:0];
            REG_SPEECH_WINDOW:   cfg_in.speech_window_ms   = csr_pwdata[CfgWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_ACTIVE_DURATION: rd_value = cfg_ff.active_duration_ms;
         REG_SPEECH_COOLDOWN: rd_value = cfg_ff.speech_cooldown_ms;
         REG_TRAVEL_MIN:      rd_value = cfg_ff.travel_min_ms;
         REG_TRAVEL_MAX:      rd_value = cfg_ff.travel_max_ms;
         REG_STROKE_HOLDOFF:  rd_value = cfg_ff.stroke_holdoff_ms;
         REG_LEVEL_WINDOW:    rd_value = cfg_ff.level_window_ms;
         REG_CLICK_QUIET:     rd_value = cfg_ff.click_quiet_ms;
         REG_SPEECH_WINDOW:   rd_value = cfg_ff.speech_window_ms;
         default:             rd_value = '0;
      endcase
   end

   assign csr_prdata = {{(CsrDataWidth-CfgWidth){1'b0}}, rd_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_duration_ms <= ActiveDurationReset;
         cfg_ff.speech_cooldown_ms <= SpeechCooldownReset;
         cfg_ff.travel_min_ms      <= TravelMinReset;
         cfg_ff.travel_max_ms      <= TravelMaxReset;
         cfg_ff.stroke_holdoff_ms  <= StrokeHoldoffReset;
         cfg_ff.level_window_ms    <= LevelWindowReset;
         cfg_ff.click_quiet_ms     <= ClickQuietReset;
         cfg_ff.speech_window_ms   <= SpeechWindowReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/tsgt_core.sv */
// Gesture state and the single-pass update that turns one request into one result.
`timescale 1ns / 1ps

module tsgt_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  tsgt_pkg::item_type   item,
   input  tsgt_pkg::cfg_type    cfg,
   output tsgt_pkg::result_type result
);
   import tsgt_pkg::*;

   logic                  touching_ff, touching_in;
   logic                  contact_blocked_ff, contact_blocked_in;
   logic                  contact_consumed_ff, contact_consumed_in;
   logic [TimeWidth-1:0]  release_time_ff, release_time_in;
   logic                  release_seen_ff, release_seen_in;
   logic [PosWidth-1:0]   origin_position_ff, origin_position_in;
   logic [TimeWidth-1:0]  origin_time_ff, origin_time_in;
   logic                  stroke_seen_ff, stroke_seen_in;
   logic [TimeWidth-1:0]  stroke_time_ff, stroke_time_in;
   logic [LevelWidth-1:0] level_count_ff, level_count_in;
   logic                  speech_pending_ff, speech_pending_in;
   logic                  speech_seen_ff, speech_seen_in;
   logic [TimeWidth-1:0]  speech_time_ff, speech_time_in;

   logic [TimeWidth-1:0]  d_stroke, d_release, d_origin, d_speech;
   logic [TimeWidth-1:0]  d_stroke_post, d_release_post, d_speech_post;
   logic [TimeWidth-1:0]  travel;
   logic [PosWidth-1:0]   pos, origin_eff, pos_gap;
   logic                  gesture, held_off, active_pre, speech_pre;
   logic                  stroke_event, speech_taken, release_now, active_post;
   logic [TimeWidth-1:0]  now;

   assign now       = item.now_ms;
   assign d_stroke  = now - stroke_time_ff;
   assign d_release = now - release_time_ff;
   assign d_origin  = now - origin_time_ff;
   assign d_speech  = now - speech_time_ff;

   assign pos        = pos_of_mask(item.zone_mask);
   assign origin_eff = touching_ff ? origin_position_ff : pos;
   assign travel     = touching_ff ? d_origin : '0;
   assign pos_gap    = (pos >= origin_eff) ? pos - origin_eff : origin_eff - pos;
   assign gesture    = item.hw_swipe ||
                       (pos_gap >= TravelHalfUnits && travel >= widen(cfg.travel_min_ms) &&
                        travel <= widen(cfg.travel_max_ms));
   assign held_off   = stroke_seen_ff && d_stroke < widen(cfg.stroke_holdoff_ms);
   assign active_pre = stroke_seen_ff && d_stroke < widen(cfg.active_duration_ms);
   assign speech_pre = speech_pending_ff && active_pre &&
                       d_stroke <= widen(cfg.speech_window_ms) &&
                       (!speech_seen_ff || d_speech >= widen(cfg.speech_cooldown_ms));

   always_comb begin
      touching_in         = touching_ff;
      contact_blocked_in  = contact_blocked_ff;
      contact_consumed_in = contact_consumed_ff;
      release_time_in     = release_time_ff;
      release_seen_in     = release_seen_ff;
      origin_position_in  = origin_position_ff;
      origin_time_in      = origin_time_ff;
      stroke_seen_in      = stroke_seen_ff;
      stroke_time_in      = stroke_time_ff;
      level_count_in      = level_count_ff;
      speech_pending_in   = speech_pending_ff;
      speech_seen_in      = speech_seen_ff;
      speech_time_in      = speech_time_ff;
      stroke_event        = 1'b0;
      speech_taken        = 1'b0;
      release_now         = 1'b0;

      if (item.func == FuncTake) begin
         if (speech_pre) begin
            speech_pending_in = 1'b0;
            speech_seen_in    = 1'b1;
            speech_time_in    = now;
            speech_taken      = 1'b1;
         end
      end else if (!item.enable) begin
         stroke_seen_in      = 1'b0;
         speech_pending_in   = 1'b0;
         level_count_in      = '0;
         touching_in         = 1'b0;
         contact_blocked_in  = (item.zone_mask != '0);
         contact_consumed_in = (item.zone_mask != '0);
         release_time_in     = now;
         release_seen_in     = 1'b1;
         release_now         = 1'b1;
      end else if (item.zone_mask == '0) begin
         if (contact_consumed_ff) begin
            release_time_in = now;
            release_seen_in = 1'b1;
            release_now     = 1'b1;
         end
         touching_in         = 1'b0;
         contact_blocked_in  = 1'b0;
         contact_consumed_in = 1'b0;
      end else if (!contact_blocked_ff) begin
         touching_in = 1'b1;
         if (gesture) begin
            origin_position_in  = pos;
            origin_time_in      = now;
            contact_consumed_in = 1'b1;
            if (!held_off) begin
               stroke_event = 1'b1;
               if (active_pre && d_stroke < widen(cfg.level_window_ms)) begin
                  level_count_in = (level_count_ff == LevelMax) ? LevelMax
                                                                 : level_count_ff + 2'd1;
               end else begin
                  level_count_in = LevelFirst;
               end
               stroke_time_in    = now;
               stroke_seen_in    = 1'b1;
               speech_pending_in = 1'b1;
            end
         end else if (!touching_ff || travel > widen(cfg.travel_max_ms)) begin
            origin_position_in = pos;
            origin_time_in     = now;
         end
      end
   end

   assign d_stroke_post  = stroke_event ? '0 : d_stroke;
   assign d_release_post = release_now ? '0 : d_release;
   assign d_speech_post  = speech_taken ? '0 : d_speech;
   assign active_post    = stroke_seen_in && d_stroke_post < widen(cfg.active_duration_ms);

   assign result.stroke_event    = stroke_event;
   assign result.speech_taken    = speech_taken;
   assign result.is_active       = active_post;
   assign result.intensity       = level_count_in;
   assign result.suppress_clicks = contact_consumed_in || contact_blocked_in ||
                                   (release_seen_in &&
                                    d_release_post < widen(cfg.click_quiet_ms));
   assign result.speech_ready    = speech_pending_in && active_post &&
                                   d_stroke_post <= widen(cfg.speech_window_ms) &&
                                   (!speech_seen_in ||
                                    d_speech_post >= widen(cfg.speech_cooldown_ms));

   always_ff @(posedge clock) begin
      if (reset) begin
         touching_ff         <= 1'b0;
         contact_blocked_ff  <= 1'b0;
         contact_consumed_ff <= 1'b0;
         release_time_ff     <= '0;
         release_seen_ff     <= 1'b0;
         origin_position_ff  <= '0;
         origin_time_ff      <= '0;
         stroke_seen_ff      <= 1'b0;
         stroke_time_ff      <= '0;
         level_count_ff      <= '0;
         speech_pending_ff   <= 1'b0;
         speech_seen_ff      <= 1'b0;
         speech_time_ff      <= '0;
      end else if (step) begin
         touching_ff         <= touching_in;
         contact_blocked_ff  <= contact_blocked_in;
         contact_consumed_ff <= contact_consumed_in;
         release_time_ff     <= release_time_in;
         release_seen_ff     <= release_seen_in;
         origin_position_ff  <= origin_position_in;
         origin_time_ff      <= origin_time_in;
         stroke_seen_ff      <= stroke_seen_in;
         stroke_time_ff      <= stroke_time_in;
         level_count_ff      <= level_count_in;
         speech_pending_ff   <= speech_pending_in;
         speech_seen_ff      <= speech_seen_in;
         speech_time_ff      <= speech_time_in;
      end
   end

endmodule

/* hdl/touch_stroke_gesture_tracker.sv */
// Top level of the touch stroke gesture tracker: request register, core and response register.
//
//   port       dir   kind            carries
//   req_chan   in    valid/ready     func, now_ms, zone_mask, hw_swipe, enable
//   rsp_chan   out   valid/ready     stroke_event, speech_taken, is_active, intensity,
//                                    suppress_clicks, speech_ready
//   csr_*      in    APB             eight 16-bit timing registers at byte address 4*i
//
// One request per cycle sustained while the response side accepts; a result passes through
// the request register, then the state update into the response register.
// Reset clears all tracking state and loads the default timings; no startup pass.
// A stalled response holds the pipeline; the request register still takes one request.
`timescale 1ns / 1ps

module touch_stroke_gesture_tracker (
   input  logic                               clock,
   input  logic                               reset,
   tsgt_req_if.sink                           req_chan,
   tsgt_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tsgt_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [tsgt_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [tsgt_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import tsgt_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type result, result_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance, step, req_ready;

   assign advance   = !out_valid_ff || rsp_chan.ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign req_chan.ready = req_ready;

   assign item_in.func      = req_chan.func;
   assign item_in.now_ms    = req_chan.now_ms;
   assign item_in.zone_mask = req_chan.zone_mask;
   assign item_in.hw_swipe  = req_chan.hw_swipe;
   assign item_in.enable    = req_chan.enable;

   assign in_valid_in  = req_ready ? req_chan.valid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   tsgt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsgt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_ready && req_chan.valid) begin
         item_ff <= item_in;
      end
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.stroke_event    = result_ff.stroke_event;
   assign rsp_chan.speech_taken    = result_ff.speech_taken;
   assign rsp_chan.is_active       = result_ff.is_active;
   assign rsp_chan.intensity       = result_ff.intensity;
   assign rsp_chan.suppress_clicks = result_ff.suppress_clicks;
   assign rsp_chan.speech_ready    = result_ff.speech_ready;

endmodule
